@@ src/swsr_pkg.sv @@
// Shared types and codes for the stack with sort and reverse.
package swsr_pkg;

    typedef logic signed [31:0] key_t;
    typedef logic [2:0]         req_t;
    typedef logic [1:0]         status_t;
    typedef logic [8:0]         depth_t;

    localparam req_t REQ_PUSH    = 3'd0;
    localparam req_t REQ_POP     = 3'd1;
    localparam req_t REQ_SORT    = 3'd2;
    localparam req_t REQ_REVERSE = 3'd3;
    localparam req_t REQ_CLEAR   = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef struct packed {
        req_t req_type;
        key_t new_key;
    } swsr_in_t;

    typedef struct packed {
        status_t status;
        key_t    popped_key;
        key_t    top_key;
        logic    top_valid;
        depth_t  depth_now;
    } swsr_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_FETCH_WAIT,
        S_SORT_LOAD,
        S_SORT_KEY,
        S_SORT_CMP,
        S_REV_RD_LO,
        S_REV_RD_HI,
        S_REV_WR_LO,
        S_REV_WR_HI
    } state_t;

endpackage

@@ src/stack_with_sort_reverse.sv @@
// Bounded LIFO stack of signed keys with in-place sort and reverse, memory based.
//
//  Channel | Ports                    | Dir | Beat
//  --------+--------------------------+-----+--------------------------------------------------
//  request | s_valid, s_ready, s_data | in  | req_type, new_key
//  result  | m_valid, m_ready, m_data | out | status, popped_key, top_key, top_valid, depth_now
//
// Push, clear, an unknown request, a failed request and a sort or reverse of fewer than two keys
// are answered from the idle state alone. A pop that leaves keys behind passes through the fetch
// states: the new top comes back through the registered read port. Sort is an insertion sort and
// reverse swaps pairs from the ends inward; both then fetch the new top. After reset the stack is
// empty and a request is taken at once; the key memory is never cleared. A request waits while
// another is in work or a held result is not being taken, so a stall holds input.

module stack_with_sort_reverse #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  swsr_pkg::swsr_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output swsr_pkg::swsr_out_t m_data
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

    // Key memory: index 0 is the bottom of the stack, fill_reg-1 the top.
    swsr_pkg::key_t key_store [STACK_DEPTH];

    swsr_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    swsr_pkg::key_t      top_reg, top_next;
    swsr_pkg::key_t      key_reg, key_next;       // insertion key, or swap holding key
    logic [AW-1:0]       i_reg, i_next;           // outer index of the sort
    logic [AW-1:0]       j_reg, j_next;           // hole position of the sort
    logic [AW-1:0]       lo_reg, lo_next;
    logic [AW-1:0]       hi_reg, hi_next;
    swsr_pkg::status_t   status_reg, status_next;
    swsr_pkg::key_t      popped_reg, popped_next;
    logic                m_valid_reg, m_valid_next;
    swsr_pkg::swsr_out_t m_data_reg, m_data_next;
    swsr_pkg::key_t      rd_data_reg;

    logic            accept;
    logic            load_out;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    swsr_pkg::key_t  wr_data;
    logic [AW-1:0]   rd_addr;
    logic            fill_lt2;
    logic            sort_more;
    logic            rev_more;

    function automatic swsr_pkg::swsr_out_t make_result(
        input swsr_pkg::status_t st,
        input swsr_pkg::key_t    popped,
        input logic [CNT_W-1:0]  cnt,
        input swsr_pkg::key_t    top
    );
        swsr_pkg::swsr_out_t r;
        r.status     = st;
        r.popped_key = popped;
        r.top_valid  = (cnt != '0);
        r.top_key    = (cnt != '0) ? top : '0;
        r.depth_now  = swsr_pkg::depth_t'(cnt);
        return r;
    endfunction

    assign s_ready  = (state_reg == swsr_pkg::S_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign fill_lt2 = (fill_reg < CNT_W'(2));
    // Another outer pass of the sort is needed while i+1 is below the fill count.
    assign sort_more = (CNT_W'(i_reg) + CNT_W'(1)) < fill_reg;
    // Another swap is needed while the two pointers have not met after stepping.
    assign rev_more  = (lo_reg + AW'(1)) < (hi_reg - AW'(1));

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            swsr_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (s_data.req_type)
                        swsr_pkg::REQ_POP: begin
                            if (fill_reg > CNT_W'(1)) begin
                                state_next = swsr_pkg::S_FETCH;
                            end
                        end
                        swsr_pkg::REQ_SORT: begin
                            if (!fill_lt2) begin
                                state_next = swsr_pkg::S_SORT_LOAD;
                            end
                        end
                        swsr_pkg::REQ_REVERSE: begin
                            if (!fill_lt2) begin
                                state_next = swsr_pkg::S_REV_RD_LO;
                            end
                        end
                        default: begin
                            state_next = swsr_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            swsr_pkg::S_FETCH:      state_next = swsr_pkg::S_FETCH_WAIT;
            swsr_pkg::S_FETCH_WAIT: state_next = swsr_pkg::S_IDLE;
            swsr_pkg::S_SORT_LOAD:  state_next = swsr_pkg::S_SORT_KEY;
            swsr_pkg::S_SORT_KEY:   state_next = swsr_pkg::S_SORT_CMP;
            swsr_pkg::S_SORT_CMP: begin
                if (!((j_reg != '0) && (rd_data_reg < key_reg))) begin
                    state_next = sort_more ? swsr_pkg::S_SORT_LOAD : swsr_pkg::S_FETCH;
                end
            end
            swsr_pkg::S_REV_RD_LO:  state_next = swsr_pkg::S_REV_RD_HI;
            swsr_pkg::S_REV_RD_HI:  state_next = swsr_pkg::S_REV_WR_LO;
            swsr_pkg::S_REV_WR_LO:  state_next = swsr_pkg::S_REV_WR_HI;
            swsr_pkg::S_REV_WR_HI: begin
                state_next = rev_more ? swsr_pkg::S_REV_RD_LO : swsr_pkg::S_FETCH;
            end
            default: state_next = swsr_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb begin
        fill_next   = fill_reg;
        top_next    = top_reg;
        key_next    = key_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        status_next = status_reg;
        popped_next = popped_reg;
        m_data_next = m_data_reg;
        load_out    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        rd_addr     = '0;

        unique case (state_reg)
            swsr_pkg::S_IDLE: begin
                if (accept) begin
                    status_next = swsr_pkg::ST_OK;
                    popped_next = '0;
                    unique case (s_data.req_type)
                        swsr_pkg::REQ_PUSH: begin
                            load_out = 1'b1;
                            if (fill_reg == DEPTH_CNT) begin
                                m_data_next = make_result(swsr_pkg::ST_FULL, '0,
                                                          fill_reg, top_reg);
                            end else begin
                                wr_en       = 1'b1;
                                wr_addr     = fill_reg[AW-1:0];
                                wr_data     = s_data.new_key;
                                fill_next   = fill_reg + CNT_W'(1);
                                top_next    = s_data.new_key;
                                m_data_next = make_result(swsr_pkg::ST_OK, '0,
                                                          fill_reg + CNT_W'(1),
                                                          s_data.new_key);
                            end
                        end
                        swsr_pkg::REQ_POP: begin
                            if (fill_reg == '0) begin
                                load_out    = 1'b1;
                                m_data_next = make_result(swsr_pkg::ST_EMPTY, '0,
                                                          fill_reg, top_reg);
                            end else begin
                                popped_next = top_reg;
                                fill_next   = fill_reg - CNT_W'(1);
                                if (fill_reg == CNT_W'(1)) begin
                                    load_out    = 1'b1;
                                    m_data_next = make_result(swsr_pkg::ST_OK, top_reg,
                                                              '0, top_reg);
                                end
                            end
                        end
                        swsr_pkg::REQ_SORT: begin
                            if (fill_lt2) begin
                                load_out    = 1'b1;
                                m_data_next = make_result(swsr_pkg::ST_OK, '0,
                                                          fill_reg, top_reg);
                            end else begin
                                i_next = AW'(1);
                            end
                        end
                        swsr_pkg::REQ_REVERSE: begin
                            if (fill_lt2) begin
                                load_out    = 1'b1;
                                m_data_next = make_result(swsr_pkg::ST_OK, '0,
                                                          fill_reg, top_reg);
                            end else begin
                                lo_next = '0;
                                hi_next = AW'(fill_reg - CNT_W'(1));
                            end
                        end
                        swsr_pkg::REQ_CLEAR: begin
                            fill_next   = '0;
                            load_out    = 1'b1;
                            m_data_next = make_result(swsr_pkg::ST_OK, '0, '0, top_reg);
                        end
                        default: begin
                            load_out    = 1'b1;
                            m_data_next = make_result(swsr_pkg::ST_OK, '0,
                                                      fill_reg, top_reg);
                        end
                    endcase
                end
            end
            swsr_pkg::S_FETCH: begin
                rd_addr = AW'(fill_reg - CNT_W'(1));
            end
            swsr_pkg::S_FETCH_WAIT: begin
                top_next    = rd_data_reg;
                load_out    = 1'b1;
                m_data_next = make_result(status_reg, popped_reg, fill_reg, rd_data_reg);
            end
            swsr_pkg::S_SORT_LOAD: begin
                rd_addr = i_reg;
            end
            swsr_pkg::S_SORT_KEY: begin
                key_next = rd_data_reg;
                j_next   = i_reg;
                rd_addr  = i_reg - AW'(1);
            end
            swsr_pkg::S_SORT_CMP: begin
                // The read data holds the key just below the hole. A smaller key
                // moves up into the hole while the next lower key is fetched.
                wr_en   = 1'b1;
                wr_addr = j_reg;
                if ((j_reg != '0) && (rd_data_reg < key_reg)) begin
                    wr_data = rd_data_reg;
                    j_next  = j_reg - AW'(1);
                    rd_addr = j_reg - AW'(2);
                end else begin
                    wr_data = key_reg;
                    i_next  = i_reg + AW'(1);
                end
            end
            swsr_pkg::S_REV_RD_LO: begin
                rd_addr = lo_reg;
            end
            swsr_pkg::S_REV_RD_HI: begin
                rd_addr  = hi_reg;
                key_next = rd_data_reg;
            end
            swsr_pkg::S_REV_WR_LO: begin
                wr_en   = 1'b1;
                wr_addr = lo_reg;
                wr_data = rd_data_reg;
            end
            swsr_pkg::S_REV_WR_HI: begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = key_reg;
                lo_next = lo_reg + AW'(1);
                hi_next = hi_reg - AW'(1);
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    // The result register fills when a result is made and empties when it is taken.
    always_comb begin
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Key memory with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_store[wr_addr] <= wr_data;
        end
        rd_data_reg <= key_store[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swsr_pkg::S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg    <= top_next;
        key_reg    <= key_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
        m_data_reg <= m_data_next;
    end

    // The fill count never passes the capacity of the key memory.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_CNT)
        else $error("fill count above stack depth");

    // A push that fits raises the count by one and puts its key on top.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.req_type == swsr_pkg::REQ_PUSH) && (fill_reg != DEPTH_CNT))
        |=> ((fill_reg == $past(fill_reg) + CNT_W'(1)) && (top_reg == $past(s_data.new_key))))
        else $error("push did not update count and top");

    // When a fetched top is turned into a result, the result register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == swsr_pkg::S_FETCH_WAIT) |-> !m_valid_reg)
        else $error("result register busy at end of a multi-cycle request");

    // A pop on a non-empty stack reports the key that was on top.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.req_type == swsr_pkg::REQ_POP) && (fill_reg != '0))
        |=> (popped_reg == $past(top_reg)))
        else $error("pop lost the top key");

endmodule
